FILE: rtl/cas_pkg.sv
// Shared types, register indexes and reset constants for the cave automaton stencil.
`default_nettype none

package cas_pkg;

    // Default grid limits for the line store depth and row counter
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int LIMIT_W     = 4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALL_FLOOR_LIMIT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR_FLOOR_LIMIT = 2'd3;

    // Reset values of the registers
    localparam int                   GRID_SIZE_RST         = 256;
    localparam logic [LIMIT_W-1:0]   WALL_FLOOR_LIMIT_RST  = 4'd5;
    localparam logic [LIMIT_W-1:0]   FLOOR_FLOOR_LIMIT_RST = 4'd2;

    // Input transaction
    typedef struct packed {
        logic req_type;
        logic cell_is_wall;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic       new_is_wall;
        logic [7:0] out_row;
        logic [7:0] out_col;
        logic       frame_done;
    } out_item_t;

    // Per-item control handed from the sequencer to the window stage
    typedef struct packed {
        logic       cell_wall;   // cell value after outside-grid forcing
        logic       use_above;   // row above is inside the grid
        logic       use_above2;  // row two above is inside the grid
        logic       emit_last;   // emits last column of the row two up
        logic       emit_mid;    // emits previous column of the row above
        logic       col_ge2;     // oldest window column is inside the row
        logic       frame_done;
        logic [7:0] res_row;
        logic [7:0] res_col;
    } seq_info_t;

endpackage

`default_nettype wire

FILE: rtl/cas_line_store.sv
// Two-row line store: one 2-bit word per column, registered read with write bypass.
`default_nettype none

module cas_line_store #(
    parameter int MAX_WIDTH = cas_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic      [1:0]                   rd_data,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire logic [1:0]                   wr_data
);

    // bit 0: row above, bit 1: row two above
    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a same-edge write to the same column is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/cas_sequencer.sv
// Raster position and frame bookkeeping: decides per item what it emits.
`default_nettype none

module cas_sequencer #(
    parameter int MAX_WIDTH  = cas_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cas_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      accept,
    input  wire cas_pkg::in_item_t                         item,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]            grid_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]           grid_h,
    input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] area,
    output logic      [$clog2(MAX_WIDTH)-1:0]              col,
    output cas_pkg::seq_info_t                             info
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT) + 1;
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] emit_cnt_reg, emit_cnt_next;

    logic [CW:0]   col_p1;
    logic [PW:0]   emit_cnt_p1;
    logic [WW-1:0] last_col;
    logic          row_end;
    logic          emit_last;
    logic          emit_mid;
    logic          frame_end;

    // Position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            emit_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // Emit decision, frame end and next position
    always_comb
    begin
        col_p1      = {1'b0, col_reg} + 1'b1;
        emit_cnt_p1 = {1'b0, emit_cnt_reg} + 1'b1;
        last_col    = grid_w - WW'(1);
        row_end     = (col_p1 >= (CW+1)'(grid_w));
        emit_last   = (col_reg == '0) && (row_reg >= RW'(2));
        emit_mid    = (col_reg != '0) && (row_reg != '0);
        frame_end   = (emit_last || emit_mid) && (emit_cnt_p1 >= (PW+1)'(area));

        if (frame_end)
        begin
            col_next      = '0;
            row_next      = '0;
            emit_cnt_next = '0;
        end
        else
        begin
            emit_cnt_next = (emit_last || emit_mid) ? PW'(emit_cnt_p1) : emit_cnt_reg;
            if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = CW'(col_p1);
                row_next = row_reg;
            end
        end

        info.cell_wall  = item.req_type || (row_reg >= RW'(grid_h)) || item.cell_is_wall;
        info.use_above  = (row_reg != '0);
        info.use_above2 = (row_reg >= RW'(2));
        info.emit_last  = emit_last;
        info.emit_mid   = emit_mid;
        info.col_ge2    = (col_reg >= CW'(2));
        info.frame_done = frame_end;
        info.res_row    = emit_mid ? 8'(row_reg - RW'(1)) : 8'(row_reg - RW'(2));
        info.res_col    = emit_mid ? 8'(col_reg - CW'(1)) : 8'(last_col);
    end

    assign col = col_reg;

endmodule

`default_nettype wire

FILE: rtl/cas_window.sv
// 3x3 window register and the wall/floor rule for the emitted cell.
`default_nettype none

module cas_window (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            fire,
    input  wire cas_pkg::seq_info_t              info,
    input  wire logic [1:0]                      rd_data,
    input  wire logic [cas_pkg::LIMIT_W-1:0]     wall_floor_limit,
    input  wire logic [cas_pkg::LIMIT_W-1:0]     floor_floor_limit,
    output logic      [1:0]                      wr_data,
    output logic                                 has_result,
    output cas_pkg::out_item_t                   result
);

    // Window bit col*3+row: column 0 oldest, row 0 topmost
    localparam logic [8:0] MASK_LAST = 9'b101_111_000;
    localparam logic [8:0] MASK_MID  = 9'b111_101_000;

    logic [8:0] win_reg, win_next;
    logic       above;
    logic       above2;
    logic [3:0] floors_last;
    logic [3:0] floors_mid;
    logic       val_last;
    logic       val_mid;

    // Floor cells among the masked window positions
    function automatic logic [3:0] floor_count(input logic [8:0] bits, input logic [8:0] mask);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 9; i++)
        begin
            n = n + 4'(mask[i] & ~bits[i]);
        end
        return n;
    endfunction

    function automatic logic next_wall(input logic center, input logic [3:0] floors,
                                       input logic [3:0] wfl, input logic [3:0] ffl);
        logic v;
        if (center)
        begin
            v = !(floors < wfl);
        end
        else
        begin
            v = (floors > ffl);
        end
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (fire)
        begin
            win_reg <= win_next;
        end
    end

    // Column fed into the window; rows above the grid read as wall
    always_comb
    begin
        above    = info.use_above ? rd_data[0] : 1'b1;
        above2   = info.use_above2 ? rd_data[1] : 1'b1;
        win_next = {info.cell_wall, above, above2, win_reg[8:3]};
        wr_data  = {above, info.cell_wall};
    end

    // Last column of an older row uses the window before the shift
    always_comb
    begin
        floors_last = floor_count(win_reg, MASK_LAST);
        floors_mid  = floor_count(win_next, MASK_MID | {6'b0, {3{info.col_ge2}}});
        val_last    = next_wall(win_reg[7], floors_last, wall_floor_limit, floor_floor_limit);
        val_mid     = next_wall(win_next[4], floors_mid, wall_floor_limit, floor_floor_limit);

        has_result         = info.emit_last || info.emit_mid;
        result.new_is_wall = info.emit_mid ? val_mid : val_last;
        result.out_row     = info.res_row;
        result.out_col     = info.res_col;
        result.frame_done  = info.frame_done;
    end

endmodule

`default_nettype wire

FILE: rtl/cave_automaton_stencil.sv
// An accepted transaction waits in the stage 1 register, its result in the output register.
// Throughput: one transaction per cycle when not stalled, set by the line store's one read
// and one write port per cycle; the first grid_width+1 transactions of a frame produce
// no result. Reset: position, frame count, window and handshake state clear; registers
// return to defaults; the line store keeps its contents and needs no clearing pass.
// Top level of the cave automaton stencil.
`default_nettype none

module cave_automaton_stencil #(
    parameter int MAX_WIDTH  = cas_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cas_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire cas_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output cas_pkg::out_item_t                       out_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cas_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [cas_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int W_RST = (cas_pkg::GRID_SIZE_RST > MAX_WIDTH) ?
                           MAX_WIDTH : cas_pkg::GRID_SIZE_RST;
    localparam int H_RST = (cas_pkg::GRID_SIZE_RST > MAX_HEIGHT) ?
                           MAX_HEIGHT : cas_pkg::GRID_SIZE_RST;
    localparam int LW    = cas_pkg::LIMIT_W;

    // Configuration registers (sizes held clamped, plus their product)
    logic [WW-1:0] grid_w_reg, grid_w_next;
    logic [HW-1:0] grid_h_reg, grid_h_next;
    logic [PW-1:0] area_reg, area_next;
    logic [LW-1:0] wfl_reg, wfl_next;
    logic [LW-1:0] ffl_reg, ffl_next;
    logic [WW-1:0] w_wr;
    logic [HW-1:0] h_wr;
    logic [WW+HW-1:0] area_prod;

    // Pipeline
    logic                load;
    logic                s1_fire;
    logic                s1_valid_reg, s1_valid_next;
    cas_pkg::seq_info_t  s1_info_reg;
    logic [CW-1:0]       s1_col_reg;
    cas_pkg::seq_info_t  seq_info;
    logic [CW-1:0]       seq_col;
    logic [1:0]          rd_data;
    logic [1:0]          wr_data;
    logic                has_result;
    cas_pkg::out_item_t  result;
    logic                out_valid_reg;
    cas_pkg::out_item_t  out_data_reg;

    // Clamp incoming sizes and form the grid area for the written register
    always_comb
    begin
        if (cfg_data < 9'd3)
        begin
            w_wr = WW'(3);
            h_wr = HW'(3);
        end
        else
        begin
            w_wr = (int'(cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
            h_wr = (int'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
        end

        grid_w_next = grid_w_reg;
        grid_h_next = grid_h_reg;
        wfl_next    = wfl_reg;
        ffl_next    = ffl_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cas_pkg::CFG_GRID_WIDTH:        grid_w_next = w_wr;
                cas_pkg::CFG_GRID_HEIGHT:       grid_h_next = h_wr;
                cas_pkg::CFG_WALL_FLOOR_LIMIT:  wfl_next    = LW'(cfg_data);
                cas_pkg::CFG_FLOOR_FLOOR_LIMIT: ffl_next    = LW'(cfg_data);
                default:                        grid_w_next = grid_w_reg;
            endcase
        end
        area_prod = grid_w_next * grid_h_next;
        area_next = PW'(area_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= WW'(W_RST);
            grid_h_reg <= HW'(H_RST);
            area_reg   <= PW'(W_RST * H_RST);
            wfl_reg    <= cas_pkg::WALL_FLOOR_LIMIT_RST;
            ffl_reg    <= cas_pkg::FLOOR_FLOOR_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            grid_w_reg <= grid_w_next;
            grid_h_reg <= grid_h_next;
            area_reg   <= area_next;
            wfl_reg    <= wfl_next;
            ffl_reg    <= ffl_next;
        end
    end

    // Handshake: stage 1 advances whenever the output register is free
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    cas_sequencer #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (load),
        .item   (in_data),
        .grid_w (grid_w_reg),
        .grid_h (grid_h_reg),
        .area   (area_reg),
        .col    (seq_col),
        .info   (seq_info)
    );

    cas_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .clk     (clk),
        .rd_en   (load),
        .rd_addr (seq_col),
        .rd_data (rd_data),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    // Stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_info_reg <= seq_info;
            s1_col_reg  <= seq_col;
        end
    end

    cas_window u_win (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (s1_fire),
        .info              (s1_info_reg),
        .rd_data           (rd_data),
        .wall_floor_limit  (wfl_reg),
        .floor_floor_limit (ffl_reg),
        .wr_data           (wr_data),
        .has_result        (has_result),
        .result            (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Frame end is only flagged on a transaction that produces a result
    a_frame_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_info_reg.frame_done |-> has_result)
        else $error("frame end flagged without a result");

    // At most one emit source per transaction
    a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !(s1_info_reg.emit_last && s1_info_reg.emit_mid))
        else $error("both emit sources active");

    // A stalled stage 1 keeps its transaction
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stage 1 lost a stalled transaction");

endmodule

`default_nettype wire

FILE: sim/cave_pass_checker.sv
// Checker for the cave automaton stencil: predicts each next-generation cell and compares.
`timescale 1ns / 1ps

module cave_pass_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  cas_pkg::in_item_t                   in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  cas_pkg::out_item_t                  out_data,
    input  logic                                cfg_wr_en,
    input  logic [cas_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int MAX_W = cas_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H = cas_pkg::MAX_HEIGHT_DEF;
    localparam int LW    = cas_pkg::LIMIT_W;

    // Register copies
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic [LW-1:0]      wall_lim;
    logic [LW-1:0]      floor_lim;

    // Line stores, window and raster position
    logic               row_above   [MAX_W];
    logic               row_above2  [MAX_W];
    logic [8:0]         win_cells;      // column 0 oldest, bit 0 of a column is the top row
    logic [8:0]         pos_row;
    logic [7:0]         pos_col;
    logic [16:0]        emitted;

    cas_pkg::out_item_t expected_cells [$];
    cas_pkg::out_item_t want;
    int                 c;

    initial fail_count = 0;

    function automatic int grid_dim(input logic [8:0] v, input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    // Floor cells in one window column, optionally skipping its middle row
    function automatic int open_cells(input logic [8:0] win, input int col, input bit skip_mid);
        int n;
        int r;
        n = 0;
        for (r = 0; r < 3; r++)
            if (!(skip_mid && r == 1) && win[col * 3 + r] == 1'b0)
                n++;
        return n;
    endfunction

    function automatic logic evolve(input logic center_wall, input int floors);
        if (center_wall)
            return (floors < int'(wall_lim)) ? 1'b0 : 1'b1;
        return (floors > int'(floor_lim)) ? 1'b1 : 1'b0;
    endfunction

    // Advance the raster position by one cell
    task automatic step_position(input int ic, input int ir, input int w);
        if (ic + 1 >= w)
        begin
            pos_col = '0;
            pos_row = 9'(ir + 1);
        end
        else
            pos_col = 8'(ic + 1);
    endtask

    // One accepted input transaction: update the window and queue the cell it completes
    task automatic predict_next_gen(input cas_pkg::in_item_t it);
        int                 w;
        int                 h;
        int                 ic;
        int                 ir;
        int                 floors;
        logic               cur_wall;
        logic               above;
        logic               above2;
        bit                 hit;
        cas_pkg::out_item_t res;

        w        = grid_dim(width_reg, MAX_W);
        h        = grid_dim(height_reg, MAX_H);
        ic       = pos_col;
        ir       = pos_row;
        hit      = 1'b0;
        res      = '0;
        cur_wall = (it.req_type || ir >= h) ? 1'b1 : it.cell_is_wall;
        above    = (ir >= 1) ? row_above[ic] : 1'b1;
        above2   = (ir >= 2) ? row_above2[ic] : 1'b1;

        // Start of a row closes the last column of the row two up
        if (ic == 0 && ir >= 2)
        begin
            floors          = open_cells(win_cells, 1, 1'b0) + open_cells(win_cells, 2, 1'b1);
            res.new_is_wall = evolve(win_cells[7], floors);
            res.out_row     = 8'(ir - 2);
            res.out_col     = 8'(w - 1);
            hit             = 1'b1;
        end

        row_above2[ic] = above;
        row_above[ic]  = cur_wall;
        win_cells      = {cur_wall, above, above2, win_cells[8:3]};

        // Previous column of the row above is now complete
        if (ic >= 1 && ir >= 1)
        begin
            floors = open_cells(win_cells, 1, 1'b1) + open_cells(win_cells, 2, 1'b0);
            if (ic >= 2)
                floors += open_cells(win_cells, 0, 1'b0);
            res.new_is_wall = evolve(win_cells[4], floors);
            res.out_row     = 8'(ir - 1);
            res.out_col     = 8'(ic - 1);
            hit             = 1'b1;
        end

        if (!hit)
            step_position(ic, ir, w);
        else if (int'(emitted) + 1 >= w * h)
        begin
            // last cell of the frame: restart at the origin
            res.frame_done = 1'b1;
            pos_row        = '0;
            pos_col        = '0;
            emitted        = '0;
            expected_cells.push_back(res);
        end
        else
        begin
            emitted = emitted + 17'd1;
            step_position(ic, ir, w);
            expected_cells.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Watch the configuration port and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = 9'(cas_pkg::GRID_SIZE_RST);
            height_reg = 9'(cas_pkg::GRID_SIZE_RST);
            wall_lim   = cas_pkg::WALL_FLOOR_LIMIT_RST;
            floor_lim  = cas_pkg::FLOOR_FLOOR_LIMIT_RST;
            for (c = 0; c < MAX_W; c++)
            begin
                row_above[c]  = 1'b0;
                row_above2[c] = 1'b0;
            end
            win_cells = '0;
            pos_row   = '0;
            pos_col   = '0;
            emitted   = '0;
            expected_cells.delete();
            pending   = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    cas_pkg::CFG_GRID_WIDTH:        width_reg  = cfg_data[8:0];
                    cas_pkg::CFG_GRID_HEIGHT:       height_reg = cfg_data[8:0];
                    cas_pkg::CFG_WALL_FLOOR_LIMIT:  wall_lim   = cfg_data[LW-1:0];
                    cas_pkg::CFG_FLOOR_FLOOR_LIMIT: floor_lim  = cfg_data[LW-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                predict_next_gen(in_data);

            if (out_valid && out_ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $error("unexpected result: row %0d col %0d", out_data.out_row,
                           out_data.out_col);
                    fail_count++;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    check_field("new_is_wall", 8'(want.new_is_wall), 8'(out_data.new_is_wall));
                    check_field("out_row", want.out_row, out_data.out_row);
                    check_field("out_col", want.out_col, out_data.out_col);
                    check_field("frame_done", 8'(want.frame_done), 8'(out_data.frame_done));
                end
            end

            pending = expected_cells.size();
        end
    end

endmodule

FILE: sim/cave_automaton_stencil_tb.sv
// Testbench top for the cave automaton stencil: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module cave_automaton_stencil_tb;

    localparam int RAND_ITEMS = 440;

    // Directed frames on a 3x3 grid, bit i is transaction i
    localparam logic [12:0] DIR1_FLUSH = 13'b1111000010000;
    localparam logic [12:0] DIR1_WALL  = 13'b1010111000101;
    localparam logic [12:0] DIR2_FLUSH = 13'b0000000000000;
    localparam logic [12:0] DIR2_WALL  = 13'b0010000101010;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    cas_pkg::in_item_t                in_data;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    cas_pkg::out_item_t               out_data;
    logic                             cfg_wr_en;
    logic [cas_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [cas_pkg::CFG_DATA_W-1:0]   cfg_data;

    int                      fail_count;
    int                      pending;
    bit                      quiet;
    int                      ready_hold = 0;
    int                      eff_w;
    int                      eff_h;

    cave_automaton_stencil dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cave_pass_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stall bursts unless quiet
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            ready_hold = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one transaction, with an optional idle burst first
    task automatic send_item(input logic flush, input logic wall);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{req_type: flush, cell_is_wall: wall};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold the input until every expected result is back, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all four registers on consecutive cycles
    task automatic set_grid(input logic [8:0] w_reg, input logic [8:0] h_reg,
                            input logic [cas_pkg::LIMIT_W-1:0] wl,
                            input logic [cas_pkg::LIMIT_W-1:0] fl);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= cas_pkg::CFG_GRID_WIDTH;
        cfg_data  <= cas_pkg::CFG_DATA_W'(w_reg);
        @(negedge clk);
        cfg_index <= cas_pkg::CFG_GRID_HEIGHT;
        cfg_data  <= cas_pkg::CFG_DATA_W'(h_reg);
        @(negedge clk);
        cfg_index <= cas_pkg::CFG_WALL_FLOOR_LIMIT;
        cfg_data  <= cas_pkg::CFG_DATA_W'(wl);
        @(negedge clk);
        cfg_index <= cas_pkg::CFG_FLOOR_FLOOR_LIMIT;
        cfg_data  <= cas_pkg::CFG_DATA_W'(fl);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        eff_w = (w_reg < 3) ? 3 :
                ((w_reg > cas_pkg::MAX_WIDTH_DEF) ? cas_pkg::MAX_WIDTH_DEF : int'(w_reg));
        eff_h = (h_reg < 3) ? 3 :
                ((h_reg > cas_pkg::MAX_HEIGHT_DEF) ? cas_pkg::MAX_HEIGHT_DEF : int'(h_reg));
    endtask

    // One whole frame plus the flush tail; wall density in percent
    task automatic drive_frame(input int density);
        int   k;
        logic flush;
        logic wall;
        for (k = 0; k < eff_w * eff_h + eff_w + 1; k++)
        begin
            wall = ($urandom_range(0, 99) < density);
            if (k < eff_w * eff_h)
                flush = ($urandom_range(0, 31) == 0);
            else
                flush = $urandom_range(0, 1);
            send_item(flush, wall);
        end
    endtask

    initial
    begin
        int          i;
        int          frames;
        int          rand_items;
        logic [8:0]  w_reg;
        logic [8:0]  h_reg;
        logic [3:0]  wl;
        logic [3:0]  fl;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        quiet      = 1'b0;
        rand_items = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Sizes below range, walls always open, floors close on any open neighbor;
        // includes a flush inside the grid
        set_grid(9'd0, 9'd1, 4'd9, 4'd0);
        for (i = 0; i < 13; i++)
            send_item(DIR1_FLUSH[i], DIR1_WALL[i]);
        drain();

        // Everything keeps its value; cell transactions past the last row act as walls
        set_grid(9'd3, 9'd3, 4'd0, 4'd8);
        for (i = 0; i < 13; i++)
            send_item(DIR2_FLUSH[i], DIR2_WALL[i]);

        // Random phases of small grids; the last ones run without idling
        while (rand_items < RAND_ITEMS)
        begin
            drain();
            quiet = (rand_items > RAND_ITEMS - 80) || ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       w_reg = 9'($urandom_range(0, 2));
                1:       w_reg = 9'($urandom_range(16, 40));
                default: w_reg = 9'($urandom_range(3, 8));
            endcase
            h_reg = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 2))
                                                : 9'($urandom_range(3, 8));
            if (w_reg > 9'd8)
                h_reg = 9'd3;
            wl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            fl = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
            set_grid(w_reg, h_reg, wl, fl);
            frames = $urandom_range(1, 3);
            repeat (frames)
                drive_frame($urandom_range(0, 100));
            rand_items += frames * (eff_w * eff_h + eff_w + 1);
        end

        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: cave_automaton_stencil.f
rtl/cas_pkg.sv
rtl/cas_line_store.sv
rtl/cas_sequencer.sv
rtl/cas_window.sv
rtl/cave_automaton_stencil.sv
sim/cave_pass_checker.sv
sim/cave_automaton_stencil_tb.sv
